[rtl/tes_pkg.sv]
// Package for the timer event scheduler: sequencer states, request codes and constants.
// No dependencies; used by rtl/timer_event_scheduler.sv.
package tes_pkg;

    localparam int DEFAULT_EVENT_TYPES = 10;

    localparam logic [1:0] REQ_SCHEDULE = 2'd0;
    localparam logic [1:0] REQ_ADVANCE  = 2'd1;
    localparam logic [1:0] REQ_FIRE     = 2'd2;

    localparam logic [3:0] TYPE_VIDEO   = 4'd0;
    localparam logic [3:0] TYPE_COMPARE = 4'd1;
    localparam logic [3:0] TYPE_CHECK   = 4'd8;

    localparam logic [63:0] COUNT_CLAMP     = 64'h0000_0000_6000_0000;
    localparam logic [32:0] COMPARE_PERIOD  = 33'h1_0000_0000;
    localparam logic [32:0] CHECK_AGAIN     = 33'd100;
    localparam logic [31:0] VI_PERIOD_RESET = 32'd1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SWEEP,
        ST_NOW_A,
        ST_NOW_B,
        ST_FIRE_CHK,
        ST_FIRE_REF,
        ST_FIRE_REARM,
        ST_REF_CHK,
        ST_REF_D,
        ST_REF_LD,
        ST_SCH_TGT,
        ST_SCH_RD,
        ST_SCH_WR,
        ST_SCH_CHK,
        ST_FIN
    } state_t;

    typedef enum logic [1:0] {
        RET_NONE,
        RET_FIN_NOW,
        RET_DONE
    } tail_t;

endpackage

[rtl/timer_event_scheduler.sv]
// Timer event scheduler top level: slot memory, sequencer and time registers.
// Depends on rtl/tes_pkg.sv for states, request codes and constants.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+---------------------------------------------------
//  request  | start, busy           | req_type, event_type, delay, elapsed, rearm_check
//  result   | done (one cycle)      | head_valid, head_type, countdown, now_time,
//           |                       | fired_valid, fired_type, other_pending, error
//  config   | cfg_we                | cfg_wdata (vi_period)
//
// Each item is handled alone; busy is high from the cycle after acceptance until done,
// which is registered and rises in the first idle cycle, where the next item may be taken.
// The cost is set by the single read port of the slot memory: every scan or rank sweep
// reads the slots one after another. An advance item runs only the final head scan and
// time step, while a schedule or a fire walks the slot memory further before that, a fire
// with re-arm the furthest.
// Reset clears the valid bits and the base, leap and remainder registers at once; no clearing pass is needed.
// The receiver cannot stall: results are shown for exactly one cycle with done high.
module timer_event_scheduler #(
    parameter int EVENT_TYPES = tes_pkg::DEFAULT_EVENT_TYPES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  req_type,
    input  logic [3:0]  event_type,
    input  logic [32:0] delay,
    input  logic [31:0] elapsed,
    input  logic        rearm_check,
    output logic        done,
    output logic        head_valid,
    output logic [3:0]  head_type,
    output logic [31:0] countdown,
    output logic [63:0] now_time,
    output logic        fired_valid,
    output logic [3:0]  fired_type,
    output logic        other_pending,
    output logic        error,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata
);

    localparam int AW = (EVENT_TYPES > 1) ? $clog2(EVENT_TYPES) : 1;
    localparam int IW = $clog2(EVENT_TYPES + 1);
    localparam int RW = AW;
    localparam int MW = 64 + RW;

    // Slot memory: target time and insertion rank of each event type.
    logic [MW-1:0] mem [EVENT_TYPES];
    logic [MW-1:0] rdata_reg;
    logic [AW-1:0] raddr_q_reg;
    logic          rd_en_q_reg;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [MW-1:0] mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;

    logic [63:0]   rd_target;
    logic [RW-1:0] rd_rank;

    tes_pkg::state_t state_reg, state_next;
    tes_pkg::state_t ret_reg, ret_next;
    tes_pkg::state_t ref_ret_reg, ref_ret_next;

    logic [EVENT_TYPES-1:0] valid_reg;
    logic [IW-1:0]          idx_reg;
    logic [31:0]            vi_period_reg;
    logic [63:0]            base_reg;
    logic [31:0]            leap_reg;
    logic [31:0]            rem_reg;
    logic [63:0]            sum_reg;
    logic [63:0]            now_reg;
    logic [63:0]            diff_reg;
    logic [63:0]            tgt_reg;
    logic [3:0]             sch_type_reg;
    logic [32:0]            sch_delay_reg;
    logic                   rearm_reg;
    logic [RW-1:0]          r_reg;
    logic                   best_v_reg;
    logic [AW-1:0]          best_idx_reg;
    logic [63:0]            best_t_reg;
    logic [RW-1:0]          best_rank_reg;
    logic                   fired_v_reg;
    logic [3:0]             fired_t_reg;
    logic                   err_reg;
    logic                   done_reg;

    logic          accept;
    logic          walk_done;
    logic [AW-1:0] sch_slot;
    logic          type_in_range;
    logic          better;
    logic          sweep_hit;
    logic [31:0]   load_val;

    assign rd_target = rdata_reg[MW-1:RW];
    assign rd_rank   = rdata_reg[RW-1:0];
    assign accept    = start && (state_reg == tes_pkg::ST_IDLE);
    assign walk_done = (idx_reg == IW'(EVENT_TYPES)) && !rd_en_q_reg;
    assign sch_slot  = sch_type_reg[AW-1:0];
    assign type_in_range = (32'(event_type) < 32'(EVENT_TYPES));

    // A slot wins the head if it is earlier, or equally early but inserted first.
    assign better = valid_reg[raddr_q_reg] &&
                    (!best_v_reg || (rd_target < best_t_reg) ||
                     ((rd_target == best_t_reg) && (rd_rank < best_rank_reg)));
    assign sweep_hit = valid_reg[raddr_q_reg] && (rd_rank > r_reg);

    // The head distance is signed: positive values above the clamp load the clamp.
    assign load_val = (!diff_reg[63] && (diff_reg > tes_pkg::COUNT_CLAMP)) ?
                      tes_pkg::COUNT_CLAMP[31:0] : diff_reg[31:0];

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg   <= mem[mem_raddr];
        raddr_q_reg <= mem_raddr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_en_q_reg <= 1'b0;
        end
        else
        begin
            rd_en_q_reg <= mem_re;
        end
    end

    // Next state and return points of the shared scan, sweep and time steps.
    always_comb
    begin
        state_next   = state_reg;
        ret_next     = ret_reg;
        ref_ret_next = ref_ret_reg;
        unique case (state_reg)
            tes_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (req_type == tes_pkg::REQ_SCHEDULE && type_in_range)
                    begin
                        state_next = tes_pkg::ST_NOW_A;
                        ret_next   = tes_pkg::ST_SCH_TGT;
                    end
                    else if (req_type == tes_pkg::REQ_FIRE)
                    begin
                        state_next = tes_pkg::ST_SCAN;
                        ret_next   = tes_pkg::ST_FIRE_CHK;
                    end
                    else
                    begin
                        state_next = tes_pkg::ST_FIN;
                    end
                end
            end
            tes_pkg::ST_SCAN, tes_pkg::ST_SWEEP:
            begin
                if (walk_done)
                begin
                    state_next = ret_reg;
                end
            end
            tes_pkg::ST_NOW_A:
            begin
                state_next = tes_pkg::ST_NOW_B;
            end
            tes_pkg::ST_NOW_B:
            begin
                state_next = ret_reg;
            end
            tes_pkg::ST_FIRE_CHK:
            begin
                if (best_v_reg)
                begin
                    state_next = tes_pkg::ST_SWEEP;
                    ret_next   = tes_pkg::ST_FIRE_REF;
                end
                else
                begin
                    state_next = tes_pkg::ST_FIN;
                end
            end
            tes_pkg::ST_FIRE_REF:
            begin
                state_next   = tes_pkg::ST_SCAN;
                ret_next     = tes_pkg::ST_REF_CHK;
                ref_ret_next = tes_pkg::ST_FIRE_REARM;
            end
            tes_pkg::ST_FIRE_REARM:
            begin
                if (fired_t_reg == tes_pkg::TYPE_VIDEO || fired_t_reg == tes_pkg::TYPE_COMPARE ||
                    (fired_t_reg == tes_pkg::TYPE_CHECK && rearm_reg))
                begin
                    state_next = tes_pkg::ST_NOW_A;
                    ret_next   = tes_pkg::ST_SCH_TGT;
                end
                else
                begin
                    state_next = tes_pkg::ST_FIN;
                end
            end
            tes_pkg::ST_REF_CHK:
            begin
                if (best_v_reg)
                begin
                    state_next = tes_pkg::ST_NOW_A;
                    ret_next   = tes_pkg::ST_REF_D;
                end
                else
                begin
                    state_next = ref_ret_reg;
                end
            end
            tes_pkg::ST_REF_D:
            begin
                state_next = tes_pkg::ST_REF_LD;
            end
            tes_pkg::ST_REF_LD:
            begin
                state_next = ref_ret_reg;
            end
            tes_pkg::ST_SCH_TGT:
            begin
                state_next = valid_reg[sch_slot] ? tes_pkg::ST_SCH_RD : tes_pkg::ST_SCH_WR;
            end
            tes_pkg::ST_SCH_RD:
            begin
                state_next = tes_pkg::ST_SWEEP;
                ret_next   = tes_pkg::ST_SCH_WR;
            end
            tes_pkg::ST_SCH_WR:
            begin
                state_next = tes_pkg::ST_SCAN;
                ret_next   = tes_pkg::ST_SCH_CHK;
            end
            tes_pkg::ST_SCH_CHK:
            begin
                if (best_idx_reg == sch_slot)
                begin
                    state_next   = tes_pkg::ST_REF_CHK;
                    ref_ret_next = tes_pkg::ST_FIN;
                end
                else
                begin
                    state_next = tes_pkg::ST_FIN;
                end
            end
            tes_pkg::ST_FIN:
            begin
                // Final scan for the head, then the current time, then the result.
                if (ret_reg == tes_pkg::ST_FIN)
                begin
                    state_next = tes_pkg::ST_NOW_A;
                    ret_next   = tes_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = tes_pkg::ST_SCAN;
                    ret_next   = tes_pkg::ST_FIN;
                end
            end
            default:
            begin
                state_next = tes_pkg::ST_IDLE;
            end
        endcase
    end

    // Handshake and memory port control.
    always_comb
    begin
        busy      = (state_reg != tes_pkg::ST_IDLE);
        done      = done_reg;
        mem_re    = 1'b0;
        mem_raddr = idx_reg[AW-1:0];
        mem_we    = 1'b0;
        mem_waddr = raddr_q_reg;
        mem_wdata = {rd_target, rd_rank - RW'(1)};
        unique case (state_reg)
            tes_pkg::ST_SCAN:
            begin
                mem_re = (idx_reg != IW'(EVENT_TYPES));
            end
            tes_pkg::ST_SWEEP:
            begin
                mem_re = (idx_reg != IW'(EVENT_TYPES));
                mem_we = rd_en_q_reg && sweep_hit;
            end
            tes_pkg::ST_SCH_TGT:
            begin
                mem_re    = 1'b1;
                mem_raddr = sch_slot;
            end
            tes_pkg::ST_SCH_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = sch_slot;
                mem_wdata = {tgt_reg, RW'($countones(valid_reg))};
            end
            default:
            begin
                mem_re = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tes_pkg::ST_IDLE;
            ret_reg       <= tes_pkg::ST_IDLE;
            ref_ret_reg   <= tes_pkg::ST_IDLE;
            valid_reg     <= '0;
            idx_reg       <= '0;
            vi_period_reg <= tes_pkg::VI_PERIOD_RESET;
            base_reg      <= '0;
            leap_reg      <= '0;
            rem_reg       <= '0;
            best_v_reg    <= 1'b0;
            fired_v_reg   <= 1'b0;
            fired_t_reg   <= '0;
            err_reg       <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            ret_reg     <= ret_next;
            ref_ret_reg <= ref_ret_next;

            // The result is shown once the final time step has landed in now_reg.
            done_reg <= (state_reg == tes_pkg::ST_NOW_B) && (ret_reg == tes_pkg::ST_IDLE);

            if (cfg_we)
            begin
                vi_period_reg <= cfg_wdata;
            end

            if (state_reg == tes_pkg::ST_SCAN || state_reg == tes_pkg::ST_SWEEP)
            begin
                if (idx_reg != IW'(EVENT_TYPES))
                begin
                    idx_reg <= idx_reg + IW'(1);
                end
            end
            else
            begin
                idx_reg <= '0;
            end

            if (state_next == tes_pkg::ST_SCAN && state_reg != tes_pkg::ST_SCAN)
            begin
                best_v_reg <= 1'b0;
            end
            else if (state_reg == tes_pkg::ST_SCAN && rd_en_q_reg && better)
            begin
                best_v_reg <= 1'b1;
            end

            unique case (state_reg)
                tes_pkg::ST_IDLE:
                begin
                    if (accept)
                    begin
                        fired_v_reg <= 1'b0;
                        fired_t_reg <= '0;
                        err_reg     <= 1'b0;
                        if (req_type == tes_pkg::REQ_ADVANCE)
                        begin
                            rem_reg <= rem_reg - elapsed;
                        end
                    end
                end
                tes_pkg::ST_FIRE_CHK:
                begin
                    if (best_v_reg)
                    begin
                        fired_v_reg             <= 1'b1;
                        fired_t_reg             <= 4'(best_idx_reg);
                        valid_reg[best_idx_reg] <= 1'b0;
                    end
                    else
                    begin
                        err_reg <= 1'b1;
                    end
                end
                tes_pkg::ST_REF_D:
                begin
                    base_reg <= now_reg;
                end
                tes_pkg::ST_REF_LD:
                begin
                    leap_reg <= load_val;
                    rem_reg  <= load_val;
                end
                tes_pkg::ST_SCH_RD:
                begin
                    valid_reg[sch_slot] <= 1'b0;
                end
                tes_pkg::ST_SCH_WR:
                begin
                    valid_reg[sch_slot] <= 1'b1;
                end
                default:
                begin
                    fired_v_reg <= fired_v_reg;
                end
            endcase
        end
    end

    // Payload registers of the datapath.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sch_type_reg  <= event_type;
            sch_delay_reg <= delay;
            rearm_reg     <= rearm_check;
        end
        if (state_reg == tes_pkg::ST_SCAN && rd_en_q_reg && better)
        begin
            best_idx_reg  <= raddr_q_reg;
            best_t_reg    <= rd_target;
            best_rank_reg <= rd_rank;
        end
        unique case (state_reg)
            tes_pkg::ST_NOW_A:
            begin
                sum_reg <= base_reg + {{32{leap_reg[31]}}, leap_reg};
            end
            tes_pkg::ST_NOW_B:
            begin
                now_reg <= sum_reg - {{32{rem_reg[31]}}, rem_reg};
            end
            tes_pkg::ST_FIRE_CHK:
            begin
                r_reg <= best_rank_reg;
            end
            tes_pkg::ST_FIRE_REARM:
            begin
                sch_type_reg <= fired_t_reg;
                if (fired_t_reg == tes_pkg::TYPE_VIDEO)
                begin
                    sch_delay_reg <= {1'b0, vi_period_reg};
                end
                else if (fired_t_reg == tes_pkg::TYPE_COMPARE)
                begin
                    sch_delay_reg <= tes_pkg::COMPARE_PERIOD;
                end
                else
                begin
                    sch_delay_reg <= tes_pkg::CHECK_AGAIN;
                end
            end
            tes_pkg::ST_REF_D:
            begin
                diff_reg <= best_t_reg - now_reg;
            end
            tes_pkg::ST_SCH_TGT:
            begin
                tgt_reg <= now_reg + {31'd0, sch_delay_reg};
            end
            tes_pkg::ST_SCH_RD:
            begin
                r_reg <= rd_rank;
            end
            default:
            begin
                sum_reg <= sum_reg;
            end
        endcase
    end

    always_comb
    begin
        head_valid    = best_v_reg;
        head_type     = best_v_reg ? 4'(best_idx_reg) : 4'd0;
        countdown     = rem_reg;
        now_time      = now_reg;
        fired_valid   = fired_v_reg;
        fired_type    = fired_t_reg;
        error         = err_reg;
        other_pending = 1'b0;
        for (int i = 0; i < EVENT_TYPES; i++)
        begin
            if (valid_reg[i] && (4'(i) != tes_pkg::TYPE_VIDEO) &&
                (4'(i) != tes_pkg::TYPE_COMPARE))
            begin
                other_pending = 1'b1;
            end
        end
    end

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held longer than one cycle");

    a_fire_or_error: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(fired_valid && error))
        else $error("fire reported both a popped event and an error");

    a_head_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (done && head_valid) |-> valid_reg[best_idx_reg])
        else $error("reported head slot is not pending");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("accepted item did not raise busy");

endmodule
